@@ rtl/core/differential_drive_move_regulator_macros.svh @@
// Assertion macros for the differential drive move regulator.
// Included by the top level; needs no other file.
`ifndef DIFFERENTIAL_DRIVE_MOVE_REGULATOR_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MOVE_REGULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DDMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ddmr_pkg.sv @@
// Package for the differential drive move regulator.
// Holds codes, sequencer states and fixed field widths; depends on nothing.
`default_nettype none

package ddmr_pkg;

  localparam int GOAL_W       = 32;
  localparam int ENC_PORT_W   = 32;
  localparam int GAIN_W       = 7;
  localparam int RAMP_W       = 16;
  localparam int FB_W         = 11;
  localparam int MUL_B_W      = FB_W + 1;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int SPEED_W      = 8;
  localparam int PREV_SPEED_W = 16;

  localparam int SPEED_MAX      = 127;
  localparam int SPEED_MIN      = -128;
  localparam int PREV_SPEED_MAX = 32767;
  localparam int PREV_SPEED_MIN = -32768;

  // Feedback is a fraction of 1024.
  localparam int FB_FRAC_BITS = 10;
  localparam int FB_UNITY     = 1024;
  localparam int FB_ROUND     = FB_UNITY - 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(50);
  localparam logic [RAMP_W-1:0] RAMP_RESET = RAMP_W'(1000);
  localparam logic [FB_W-1:0]   FB_RESET   = FB_W'(400);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MV_IDLE    = 2'd0,
    MV_FORWARD = 2'd1,
    MV_TURNING = 2'd2
  } move_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_GAIN    = 2'd0,
    REG_RAMP_DISTANCE = 2'd1,
    REG_FORWARD_FB    = 2'd2,
    REG_TURNING_FB    = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_SUM,
    SQ_DIST,
    SQ_NEAR,
    SQ_MULN,
    SQ_DIV,
    SQ_MULC,
    SQ_MULP,
    SQ_CHECK,
    SQ_SAT,
    SQ_DONE
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/core/differential_drive_move_regulator.sv @@
// Differential drive move regulator: position P controller for a two-wheel base.
// Depends on ddmr_pkg and differential_drive_move_regulator_macros.svh.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready   | action, move_mode, target, two encoders
//   out_    | output    | out_valid/out_ready | speeds_sent, speed_one, speed_two, idle
//   cfg_    | input     | cfg_wr_en           | cfg_index, cfg_data
//
// A poll of an active move steps through SUM, DIST, NEAR, MULN, DIV, MULC, MULP, CHECK and SAT
// before the result register; the restoring divider in DIV gives one quotient bit a cycle.
// Start, stop, no-op items and polls while idle write the result register on acceptance.
// The block takes the next item once its result is in the output register.
// A stalled output only holds a finished result in the sequencer until the register frees.
// Reset is synchronous and restores the configuration defaults and an idle move.
`default_nettype none

module differential_drive_move_regulator #(
  parameter int ENCODER_BITS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [1:0]                             in_action,
  input  wire logic                                   in_move_mode,
  input  wire logic signed [ddmr_pkg::GOAL_W-1:0]     in_target_ticks,
  input  wire logic signed [ddmr_pkg::ENC_PORT_W-1:0] in_encoder_one,
  input  wire logic signed [ddmr_pkg::ENC_PORT_W-1:0] in_encoder_two,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_speeds_sent,
  output logic signed [ddmr_pkg::SPEED_W-1:0]         out_speed_one,
  output logic signed [ddmr_pkg::SPEED_W-1:0]         out_speed_two,
  output logic                                        out_idle,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [ddmr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ddmr_pkg::CFG_W-1:0]             cfg_data
);

  `include "differential_drive_move_regulator_macros.svh"

  localparam int EB    = ENCODER_BITS;
  localparam int MW    = EB + 1;                      // motion and imbalance
  localparam int DW    = ddmr_pkg::GOAL_W + 2;        // remaining distance
  localparam int NW    = MW;                          // nearer of the two magnitudes
  localparam int AW    = MW + 1;                      // multiplier operand A
  localparam int PW    = AW + ddmr_pkg::MUL_B_W;      // product
  localparam int QW    = NW + ddmr_pkg::GAIN_W;       // dividend and quotient
  localparam int VW    = QW + 2;                      // signed ramp speed
  localparam int CW    = PW - ddmr_pkg::FB_FRAC_BITS; // correction
  localparam int SW    = VW + 1;                      // speed plus correction
  localparam int RW    = ddmr_pkg::RAMP_W;
  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;
  localparam int OW    = ddmr_pkg::SPEED_W;
  localparam int PSW   = ddmr_pkg::PREV_SPEED_W;

  localparam logic signed [SW-1:0] S8_HI  = SW'(ddmr_pkg::SPEED_MAX);
  localparam logic signed [SW-1:0] S8_LO  = SW'(ddmr_pkg::SPEED_MIN);
  localparam logic signed [VW-1:0] S16_HI = VW'(ddmr_pkg::PREV_SPEED_MAX);
  localparam logic signed [VW-1:0] S16_LO = VW'(ddmr_pkg::PREV_SPEED_MIN);

  // Sequencer
  ddmr_pkg::seq_state_t state_r, state_nxt;
  logic in_fire, out_load;

  // Configuration
  logic [ddmr_pkg::GAIN_W-1:0] gain_r;
  logic [RW-1:0]               ramp_r;
  logic [ddmr_pkg::FB_W-1:0]   ffb_r, tfb_r;

  // Move state
  ddmr_pkg::move_state_t   move_r;
  logic signed [ddmr_pkg::GOAL_W-1:0] goal_r;
  logic [EB-1:0]           start1_r, start2_r;
  logic signed [PSW-1:0]   prev_speed_r;
  logic signed [MW-1:0]    prev_imb_r;

  // Working registers of one poll
  logic                    fwd_r;
  logic [EB-1:0]           d1_r, d2_r;
  logic signed [MW-1:0]    motion_r, imb_r;
  logic signed [DW-1:0]    dist_r;
  logic                    dist_pos_r, dist_zero_r;
  logic [NW-1:0]           near_r;
  logic [QW-1:0]           q_r;
  logic [RW-1:0]           rem_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [VW-1:0]    v_r;
  logic signed [CW-1:0]    c_r;
  logic signed [SW-1:0]    diff_r, sum_r;
  logic                    stop_r;

  // Result waiting for the output register
  logic                    res_sent_r, res_idle_r;
  logic signed [OW-1:0]    res_s1_r, res_s2_r;

  // Output register
  logic                    out_valid_r, out_sent_r, out_idle_r;
  logic signed [OW-1:0]    out_s1_r, out_s2_r;

  // ---------------------------------------------------------------------------
  // Shared multiplier and datapath helpers

  logic [ddmr_pkg::FB_W-1:0]       fb_eff;
  logic signed [AW-1:0]            mul_a;
  logic signed [ddmr_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]            mul_p;

  always_comb begin
    fb_eff = fwd_r ? ffb_r : tfb_r;
    if (fb_eff == '0) begin
      fb_eff = ddmr_pkg::FB_W'(1);
    end
    unique case (state_r)
      ddmr_pkg::SQ_MULN: begin
        mul_a = $signed({1'b0, near_r});
        mul_b = $signed(ddmr_pkg::MUL_B_W'(gain_r));
      end
      ddmr_pkg::SQ_MULC: begin
        mul_a = AW'(imb_r);
        mul_b = $signed(ddmr_pkg::MUL_B_W'(fb_eff));
      end
      default: begin
        mul_a = AW'(prev_imb_r);
        mul_b = $signed(ddmr_pkg::MUL_B_W'(fb_eff));
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Motion and imbalance from the two deltas; the mode swaps sum and difference.
  logic signed [MW-1:0] dsum, ddif;
  assign dsum = MW'($signed(d1_r)) + MW'($signed(d2_r));
  assign ddif = MW'($signed(d1_r)) - MW'($signed(d2_r));

  logic signed [DW-1:0] mot_ext;
  logic [DW-1:0]        dist_mag, mot_mag;
  assign mot_ext  = DW'(motion_r);
  assign dist_mag = dist_r[DW-1] ? DW'(-dist_r) : DW'(dist_r);
  assign mot_mag  = mot_ext[DW-1] ? DW'(-mot_ext) : DW'(mot_ext);

  // One restoring division step.
  logic [RW-1:0] divisor;
  logic [RW:0]   rem_sh;
  logic          div_ge;
  assign divisor = (ramp_r == '0) ? RW'(1) : ramp_r;
  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign div_ge  = rem_sh >= {1'b0, divisor};

  // Correction truncated toward zero.
  logic signed [PW-1:0] prod_biased;
  assign prod_biased = prod_r + (prod_r[PW-1] ? PW'(ddmr_pkg::FB_ROUND) : PW'(0));

  logic prev_small;
  assign prev_small = (prev_speed_r == PSW'(0)) || (prev_speed_r == PSW'(1))
                   || (prev_speed_r == PSW'(-1));

  logic signed [SW-1:0] side2;
  logic signed [OW-1:0] s1_sat, s2_sat;
  logic signed [PSW-1:0] v_sat;

  always_comb begin
    side2 = fwd_r ? sum_r : -sum_r;
    if (diff_r > S8_HI) begin
      s1_sat = OW'(ddmr_pkg::SPEED_MAX);
    end else if (diff_r < S8_LO) begin
      s1_sat = OW'(ddmr_pkg::SPEED_MIN);
    end else begin
      s1_sat = diff_r[OW-1:0];
    end
    if (side2 > S8_HI) begin
      s2_sat = OW'(ddmr_pkg::SPEED_MAX);
    end else if (side2 < S8_LO) begin
      s2_sat = OW'(ddmr_pkg::SPEED_MIN);
    end else begin
      s2_sat = side2[OW-1:0];
    end
    if (v_r > S16_HI) begin
      v_sat = PSW'(ddmr_pkg::PREV_SPEED_MAX);
    end else if (v_r < S16_LO) begin
      v_sat = PSW'(ddmr_pkg::PREV_SPEED_MIN);
    end else begin
      v_sat = v_r[PSW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddmr_pkg::SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ddmr_pkg::SQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((ddmr_pkg::action_t'(in_action) == ddmr_pkg::ACT_POLL)
              && (move_r != ddmr_pkg::MV_IDLE)) begin
            state_nxt = ddmr_pkg::SQ_SUM;
          end else begin
            state_nxt = ddmr_pkg::SQ_DONE;
          end
        end
      end
      ddmr_pkg::SQ_SUM:   state_nxt = ddmr_pkg::SQ_DIST;
      ddmr_pkg::SQ_DIST:  state_nxt = ddmr_pkg::SQ_NEAR;
      ddmr_pkg::SQ_NEAR:  state_nxt = ddmr_pkg::SQ_MULN;
      ddmr_pkg::SQ_MULN:  state_nxt = ddmr_pkg::SQ_DIV;
      ddmr_pkg::SQ_DIV: begin
        if (cnt_r == CNT_W'(QW - 1)) begin
          state_nxt = ddmr_pkg::SQ_MULC;
        end
      end
      ddmr_pkg::SQ_MULC:  state_nxt = ddmr_pkg::SQ_MULP;
      ddmr_pkg::SQ_MULP:  state_nxt = ddmr_pkg::SQ_CHECK;
      ddmr_pkg::SQ_CHECK: state_nxt = ddmr_pkg::SQ_SAT;
      ddmr_pkg::SQ_SAT:   state_nxt = ddmr_pkg::SQ_DONE;
      ddmr_pkg::SQ_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ddmr_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = ddmr_pkg::SQ_IDLE;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Configuration registers

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= ddmr_pkg::GAIN_RESET;
      ramp_r <= ddmr_pkg::RAMP_RESET;
      ffb_r  <= ddmr_pkg::FB_RESET;
      tfb_r  <= ddmr_pkg::FB_RESET;
    end else if (cfg_wr_en) begin
      unique case (ddmr_pkg::cfg_reg_t'(cfg_index))
        ddmr_pkg::REG_SPEED_GAIN:    gain_r <= cfg_data[ddmr_pkg::GAIN_W-1:0];
        ddmr_pkg::REG_RAMP_DISTANCE: ramp_r <= cfg_data[RW-1:0];
        ddmr_pkg::REG_FORWARD_FB:    ffb_r  <= cfg_data[ddmr_pkg::FB_W-1:0];
        ddmr_pkg::REG_TURNING_FB:    tfb_r  <= cfg_data[ddmr_pkg::FB_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Move state

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_r       <= ddmr_pkg::MV_IDLE;
      goal_r       <= '0;
      start1_r     <= '0;
      start2_r     <= '0;
      prev_speed_r <= '0;
      prev_imb_r   <= '0;
    end else if (in_fire) begin
      unique case (ddmr_pkg::action_t'(in_action))
        ddmr_pkg::ACT_START: begin
          move_r   <= in_move_mode ? ddmr_pkg::MV_TURNING : ddmr_pkg::MV_FORWARD;
          goal_r   <= in_target_ticks;
          start1_r <= in_encoder_one[EB-1:0];
          start2_r <= in_encoder_two[EB-1:0];
        end
        ddmr_pkg::ACT_STOP: move_r <= ddmr_pkg::MV_IDLE;
        default: ;
      endcase
    end else if (state_r == ddmr_pkg::SQ_SAT) begin
      if (stop_r) begin
        move_r <= ddmr_pkg::MV_IDLE;
      end else begin
        prev_speed_r <= v_sat;
        prev_imb_r   <= imb_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Poll datapath, one step per sequencer state

  always_ff @(posedge clk) begin
    unique case (state_r)
      ddmr_pkg::SQ_IDLE: begin
        d1_r  <= in_encoder_one[EB-1:0] - start1_r;
        d2_r  <= in_encoder_two[EB-1:0] - start2_r;
        fwd_r <= (move_r == ddmr_pkg::MV_FORWARD);
      end
      ddmr_pkg::SQ_SUM: begin
        motion_r <= fwd_r ? dsum : ddif;
        imb_r    <= fwd_r ? ddif : dsum;
      end
      ddmr_pkg::SQ_DIST: begin
        dist_r <= DW'(goal_r) - DW'(motion_r);
      end
      ddmr_pkg::SQ_NEAR: begin
        near_r      <= (dist_mag < mot_mag) ? dist_mag[NW-1:0] : mot_mag[NW-1:0];
        dist_pos_r  <= !dist_r[DW-1] && (dist_r != '0);
        dist_zero_r <= (dist_r == '0);
      end
      ddmr_pkg::SQ_MULN: begin
        q_r   <= mul_p[QW-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      ddmr_pkg::SQ_DIV: begin
        rem_r <= div_ge ? RW'(rem_sh - {1'b0, divisor}) : rem_sh[RW-1:0];
        q_r   <= {q_r[QW-2:0], div_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ddmr_pkg::SQ_MULC: begin
        // The negated speed -(q+1) is the complement of q.
        v_r    <= dist_pos_r ? $signed(VW'(q_r) + VW'(1)) : $signed(~VW'(q_r));
        prod_r <= mul_p;
      end
      ddmr_pkg::SQ_MULP: begin
        c_r    <= prod_biased[PW-1:ddmr_pkg::FB_FRAC_BITS];
        prod_r <= mul_p;
      end
      ddmr_pkg::SQ_CHECK: begin
        // Imbalance at most 1024/feedback, tested as imbalance*feedback <= 1024.
        // Any negative imbalance passes.
        stop_r <= dist_zero_r && prev_small
               && (prev_imb_r[MW-1] || (prod_r <= $signed(PW'(ddmr_pkg::FB_UNITY))));
        diff_r <= SW'(v_r) - SW'(c_r);
        sum_r  <= SW'(v_r) + SW'(c_r);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result of the current item

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_s1_r <= '0;
      res_s2_r <= '0;
      unique case (ddmr_pkg::action_t'(in_action))
        ddmr_pkg::ACT_START: begin
          res_sent_r <= 1'b0;
          res_idle_r <= 1'b0;
        end
        ddmr_pkg::ACT_STOP: begin
          res_sent_r <= 1'b1;
          res_idle_r <= 1'b1;
        end
        default: begin
          res_sent_r <= 1'b0;
          res_idle_r <= (move_r == ddmr_pkg::MV_IDLE);
        end
      endcase
    end else if (state_r == ddmr_pkg::SQ_SAT) begin
      res_sent_r <= 1'b1;
      res_idle_r <= stop_r;
      res_s1_r   <= stop_r ? OW'(0) : s1_sat;
      res_s2_r   <= stop_r ? OW'(0) : s2_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sent_r <= res_sent_r;
      out_idle_r <= res_idle_r;
      out_s1_r   <= res_s1_r;
      out_s2_r   <= res_s2_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_speeds_sent = out_sent_r;
  assign out_idle        = out_idle_r;
  assign out_speed_one   = out_s1_r;
  assign out_speed_two   = out_s2_r;

  // ---------------------------------------------------------------------------
  // Assertions

  `DDMR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready,
    "input accepted while an item is still in work")
  `DDMR_ASSERT_NOW(a_quiet_zero, clk, rst_n, out_valid_r && !out_sent_r,
    (out_s1_r == '0) && (out_s2_r == '0), "nonzero speeds on a result that sends none")
  `DDMR_ASSERT_NOW(a_idle_zero, clk, rst_n, out_valid_r && out_sent_r && out_idle_r,
    (out_s1_r == '0) && (out_s2_r == '0), "nonzero speeds on a result that halts")
  `DDMR_ASSERT_NEXT(a_load_from_done, clk, rst_n, out_load, out_valid_r,
    "result register not loaded")

endmodule

`default_nettype wire

@@ sim/differential_drive_move_regulator_tb.sv @@
// Testbench for the differential drive move regulator: directed table, then random moves.
// Checks results against typed rows or a speed predictor; needs ddmr_pkg and the block.
`timescale 1ns / 100ps

module differential_drive_move_regulator_tb;

  localparam int SEG_ITEMS    = 42;
  localparam int NUM_SEGS     = 9;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    ddmr_pkg::action_t   action;
    logic                move_mode;
    logic signed [31:0]  target;
    logic signed [31:0]  enc_one;
    logic signed [31:0]  enc_two;
  } move_item_t;

  typedef struct packed {
    logic                sent;
    logic signed [7:0]   speed_one;
    logic signed [7:0]   speed_two;
    logic                idle;
  } move_result_t;

  typedef struct packed {
    move_item_t   item;
    logic         typed;
    move_result_t want;
  } dir_row_t;

  typedef struct packed {
    logic        rand_fill;
    logic [15:0] gain;
    logic [15:0] ramp;
    logic [15:0] fwd_fb;
    logic [15:0] turn_fb;
  } cfg_row_t;

  // Under the reset settings the stop threshold on the imbalance is 1024/400 = 2.
  localparam dir_row_t DIRECTED [24] = '{
    '{'{ddmr_pkg::ACT_POLL,  1'b1, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b1}},
    '{'{ddmr_pkg::ACT_STOP,  1'b0, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b1,
      '{1'b1, 8'sd0, 8'sd0, 1'b1}},
    '{'{ddmr_pkg::ACT_NONE,  1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b1}},
    '{'{ddmr_pkg::ACT_START, 1'b0, 32'sd1000,    32'h00000000, 32'h00000000}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b1,
      '{1'b1, 8'sd1, 8'sd1, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'sd500,     32'sd500},     1'b1,
      '{1'b1, 8'sd0, 8'sd0, 1'b1}},
    '{'{ddmr_pkg::ACT_START, 1'b1, -32'sd200,    32'sd100,     32'sd100},     1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b1, 32'h00000000, 32'sd50,      32'sd150},     1'b0, '0},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'sd0,       32'sd200},     1'b0, '0},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'sd0,       32'sd200},     1'b0, '0},
    '{'{ddmr_pkg::ACT_START, 1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000}, 1'b0, '0},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'h00000000, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'hC0000000, 32'h3FFFFFFF}, 1'b0, '0},
    '{'{ddmr_pkg::ACT_NONE,  1'b0, 32'h12345678, 32'h0F0F0F0F, 32'hF0F0F0F0}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_STOP,  1'b1, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA}, 1'b1,
      '{1'b1, 8'sd0, 8'sd0, 1'b1}},
    '{'{ddmr_pkg::ACT_START, 1'b1, 32'h80000000, 32'h00000000, 32'h00000000}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b1, 32'h00000000, 32'sd12345,   32'sd54321},   1'b0, '0},
    '{'{ddmr_pkg::ACT_START, 1'b0, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b0, '0},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'h00000000, 32'h00000000}, 1'b0, '0},
    '{'{ddmr_pkg::ACT_START, 1'b0, 32'sd10,      32'h00000000, 32'h00000000}, 1'b1,
      '{1'b0, 8'sd0, 8'sd0, 1'b0}},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, 32'sd0,       32'sd5},       1'b0, '0},
    '{'{ddmr_pkg::ACT_POLL,  1'b0, 32'h00000000, -32'sd5,      32'sd15},      1'b0, '0}
  };

  localparam cfg_row_t CFG_PLAN [NUM_SEGS] = '{
    '{1'b0, 16'd50,  16'd1000,  16'd400,  16'd400},
    '{1'b0, 16'd127, 16'd65535, 16'd1024, 16'd1024},
    '{1'b0, 16'd0,   16'd1,     16'd1,    16'd1},
    '{1'b0, 16'd100, 16'd0,     16'd0,    16'd2047},
    '{1'b0, 16'd127, 16'd16,    16'd1000, 16'd3},
    '{1'b1, 16'd0,   16'd0,     16'd0,    16'd0},
    '{1'b0, 16'd90,  16'd200,   16'd512,  16'd256},
    '{1'b0, 16'd64,  16'd1,     16'd1024, 16'd1},
    '{1'b1, 16'd0,   16'd0,     16'd0,    16'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_action = 2'd0;
  logic                 in_move_mode = 1'b0;
  logic signed [31:0]   in_target_ticks = '0;
  logic signed [31:0]   in_encoder_one = '0;
  logic signed [31:0]   in_encoder_two = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_speeds_sent;
  logic signed [7:0]    out_speed_one;
  logic signed [7:0]    out_speed_two;
  logic                 out_idle;
  logic                 cfg_wr_en = 1'b0;
  logic [ddmr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ddmr_pkg::CFG_W-1:0]     cfg_data = '0;

  // Predictor copy of the configuration and the move state.
  logic [ddmr_pkg::GAIN_W-1:0] gain_q;
  logic [ddmr_pkg::RAMP_W-1:0] ramp_q;
  logic [ddmr_pkg::FB_W-1:0]   fwd_fb_q;
  logic [ddmr_pkg::FB_W-1:0]   turn_fb_q;
  ddmr_pkg::move_state_t       move_q;
  longint               goal_q;
  logic [31:0]          base_one_q;
  logic [31:0]          base_two_q;
  longint               last_speed_q;
  longint               last_imbalance_q;

  move_result_t         speed_expect [$];
  int                   mismatches = 0;
  int                   items_sent = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;

  differential_drive_move_regulator #(
    .ENCODER_BITS(ddmr_pkg::ENC_PORT_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_move_mode   (in_move_mode),
    .in_target_ticks(in_target_ticks),
    .in_encoder_one (in_encoder_one),
    .in_encoder_two (in_encoder_two),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_speeds_sent(out_speeds_sent),
    .out_speed_one  (out_speed_one),
    .out_speed_two  (out_speed_two),
    .out_idle       (out_idle),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Advances the predictor by one accepted item and returns the speeds it should produce.
  function automatic move_result_t predict_speeds(move_item_t it);
    move_result_t r;
    logic [31:0]  w1, w2;
    longint       d1, d2, motion, imbalance, fb, divisor, remaining, near, v, corr;
    logic         fwd;
    r = '0;
    case (it.action)
      ddmr_pkg::ACT_START: begin
        move_q     = it.move_mode ? ddmr_pkg::MV_TURNING : ddmr_pkg::MV_FORWARD;
        goal_q     = longint'($signed(it.target));
        base_one_q = it.enc_one;
        base_two_q = it.enc_two;
      end
      ddmr_pkg::ACT_STOP: begin
        move_q = ddmr_pkg::MV_IDLE;
        r.sent = 1'b1;
      end
      ddmr_pkg::ACT_POLL: begin
        if (move_q != ddmr_pkg::MV_IDLE) begin
          fwd = (move_q == ddmr_pkg::MV_FORWARD);
          // Deltas wrap at the encoder width before they are widened.
          w1 = it.enc_one - base_one_q;
          w2 = it.enc_two - base_two_q;
          d1 = longint'($signed(w1));
          d2 = longint'($signed(w2));
          motion    = fwd ? d1 + d2 : d1 - d2;
          imbalance = fwd ? d1 - d2 : d1 + d2;
          fb = fwd ? longint'(fwd_fb_q) : longint'(turn_fb_q);
          if (fb == 0) fb = 1;
          divisor = (ramp_q == 0) ? 1 : longint'(ramp_q);
          remaining = goal_q - motion;
          near = (magnitude(remaining) < magnitude(motion)) ? magnitude(remaining)
                                                             : magnitude(motion);
          v = near * longint'(gain_q) / divisor + 1;
          if (remaining <= 0) v = -v;
          r.sent = 1'b1;
          // The imbalance compare is signed, so a negative imbalance always passes.
          if (remaining == 0 && magnitude(last_speed_q) <= 1 &&
              last_imbalance_q <= longint'(ddmr_pkg::FB_UNITY) / fb) begin
            move_q = ddmr_pkg::MV_IDLE;
          end else begin
            corr = imbalance * fb / longint'(ddmr_pkg::FB_UNITY);
            last_speed_q     = clamp_to(v, ddmr_pkg::PREV_SPEED_MIN,
                                        ddmr_pkg::PREV_SPEED_MAX);
            last_imbalance_q = imbalance;
            r.speed_one = 8'(clamp_to(v - corr, ddmr_pkg::SPEED_MIN, ddmr_pkg::SPEED_MAX));
            r.speed_two = 8'(clamp_to(fwd ? v + corr : -v - corr,
                                      ddmr_pkg::SPEED_MIN, ddmr_pkg::SPEED_MAX));
          end
        end
      end
      default: ;
    endcase
    r.idle = (move_q == ddmr_pkg::MV_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_result();
    move_result_t want;
    if (speed_expect.size() == 0) begin
      report_mismatch("result arrived with nothing expected");
      return;
    end
    want = speed_expect.pop_front();
    if (out_speeds_sent !== want.sent)
      report_mismatch($sformatf("speeds_sent %b, expected %b", out_speeds_sent, want.sent));
    if (out_speed_one !== want.speed_one)
      report_mismatch($sformatf("speed_one %0d, expected %0d", out_speed_one, want.speed_one));
    if (out_speed_two !== want.speed_two)
      report_mismatch($sformatf("speed_two %0d, expected %0d", out_speed_two, want.speed_two));
    if (out_idle !== want.idle)
      report_mismatch($sformatf("idle %b, expected %b", out_idle, want.idle));
  endtask

  // Receiver: checks accepted results and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid is only dropped when a gap follows, so it never toggles within one step.
  task automatic push_item(input move_item_t it, input logic typed, input move_result_t want);
    move_result_t predicted;
    int           gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= it.action;
    in_move_mode    <= it.move_mode;
    in_target_ticks <= it.target;
    in_encoder_one  <= it.enc_one;
    in_encoder_two  <= it.enc_two;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_speeds(it);
    speed_expect.push_back(typed ? want : predicted);
    if (it.action != ddmr_pkg::ACT_NONE) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (speed_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ddmr_pkg::cfg_reg_t idx,
                           input logic [ddmr_pkg::CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      ddmr_pkg::REG_SPEED_GAIN:    gain_q    = value[ddmr_pkg::GAIN_W-1:0];
      ddmr_pkg::REG_RAMP_DISTANCE: ramp_q    = value[ddmr_pkg::RAMP_W-1:0];
      ddmr_pkg::REG_FORWARD_FB:    fwd_fb_q  = value[ddmr_pkg::FB_W-1:0];
      ddmr_pkg::REG_TURNING_FB:    turn_fb_q = value[ddmr_pkg::FB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(input cfg_row_t row);
    if (row.rand_fill) begin
      row.gain    = 16'($urandom);
      row.ramp    = 16'($urandom);
      row.fwd_fb  = 16'($urandom);
      row.turn_fb = 16'($urandom);
    end
    write_reg(ddmr_pkg::REG_SPEED_GAIN, row.gain);
    write_reg(ddmr_pkg::REG_RAMP_DISTANCE, row.ramp);
    write_reg(ddmr_pkg::REG_FORWARD_FB, row.fwd_fb);
    write_reg(ddmr_pkg::REG_TURNING_FB, row.turn_fb);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic move_item_t noise_item();
    move_item_t it;
    it.action    = ddmr_pkg::action_t'($urandom_range(3));
    it.move_mode = 1'($urandom_range(1));
    it.target    = $urandom;
    it.enc_one   = $urandom;
    it.enc_two   = $urandom;
    return it;
  endfunction

  // One move: a start, polls closing in on the target, then polls sitting on it.
  task automatic random_move();
    move_item_t it;
    logic [31:0] base_one, base_two;
    longint      tgt, m, bal, h1, h2;
    int          steps;
    logic        turning;
    turning = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       tgt = longint'($signed($urandom));
      1, 2:    tgt = longint'(int'($urandom_range(200)) - 100);
      default: tgt = longint'(int'($urandom_range(10000)) - 5000);
    endcase
    base_one = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
    base_two = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
    it = noise_item();
    it.action    = ddmr_pkg::ACT_START;
    it.move_mode = turning;
    it.target    = 32'(tgt);
    it.enc_one   = base_one;
    it.enc_two   = base_two;
    push_item(it, 1'b0, '0);
    steps = $urandom_range(1, 6);
    for (int i = 1; i <= steps + 2; i++) begin
      if (i >= steps) m = tgt;
      else m = tgt * i / steps + longint'(int'($urandom_range(20)) - 10);
      case ($urandom_range(9))
        0:       bal = longint'($signed($urandom)) >>> 4;
        1:       bal = longint'(int'($urandom_range(4000)) - 2000);
        default: bal = longint'(int'($urandom_range(6)) - 3);
      endcase
      if (i >= steps && $urandom_range(1) == 0) bal = 0;
      h1 = (m + bal) >>> 1;
      h2 = turning ? h1 - m : m - h1;
      it = noise_item();
      it.action  = ddmr_pkg::ACT_POLL;
      it.enc_one = base_one + 32'(h1);
      it.enc_two = base_two + 32'(h2);
      push_item(it, 1'b0, '0);
      // Now and then a stray item breaks into the sequence.
      if ($urandom_range(11) == 0) push_item(noise_item(), 1'b0, '0);
    end
  endtask

  initial begin
    int seg_goal;
    gain_q           = ddmr_pkg::GAIN_RESET;
    ramp_q           = ddmr_pkg::RAMP_RESET;
    fwd_fb_q         = ddmr_pkg::FB_RESET;
    turn_fb_q        = ddmr_pkg::FB_RESET;
    move_q           = ddmr_pkg::MV_IDLE;
    goal_q           = 0;
    base_one_q       = '0;
    base_two_q       = '0;
    last_speed_q     = 0;
    last_imbalance_q = 0;
    send_idle_pct    = 35;
    recv_idle_pct    = 59;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) push_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      program_settings(CFG_PLAN[seg]);
      case (seg / 3)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      seg_goal = items_sent + SEG_ITEMS;
      while (items_sent < seg_goal) begin
        if ($urandom_range(4) == 0) push_item(noise_item(), 1'b0, '0);
        else random_move();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ddmr_pkg.sv
rtl/core/differential_drive_move_regulator.sv
sim/differential_drive_move_regulator_tb.sv
